[src/multipart_upload_boundary_scanner_defines.svh]
// assertion macros used by the checker file
`ifndef MULTIPART_UPLOAD_BOUNDARY_SCANNER_DEFINES_SVH
`define MULTIPART_UPLOAD_BOUNDARY_SCANNER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MUBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MUBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/mubs_pkg.sv]
// ----------------------------------------------------------------------------
// mubs_pkg
// Shared constants, status codes and the field-text matcher of the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mubs_pkg;

  localparam int MAX_DELIMITER_DEF = 80;
  localparam int FIELD_LEN = 15;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_BOUNDARY = 3'd1;
  localparam logic [2:0] ST_NO_FIELD    = 3'd2;
  localparam logic [2:0] ST_NO_HDR_END  = 3'd3;
  localparam logic [2:0] ST_EMPTY       = 3'd4;

  localparam logic [7:0] FIELD_TEXT [FIELD_LEN] = '{
    8'h6E, 8'h61, 8'h6D, 8'h65, 8'h3D, 8'h22, 8'h66, 8'h69,
    8'h6C, 8'h65, 8'h6E, 8'h61, 8'h6D, 8'h65, 8'h22
  };

  // next progress of the name="filename" search, p below FIELD_LEN
  function automatic logic [3:0] field_next(input logic [3:0] p, input logic [7:0] b);
    logic [3:0] np;
    logic       done;
    logic       ok;
    logic [4:0] idx;
    np   = 4'd0;
    done = 1'b0;
    if (p < 4'(FIELD_LEN) && b == FIELD_TEXT[p]) begin
      np = p + 4'd1;
    end else begin
      for (int k = FIELD_LEN - 1; k >= 1; k--) begin
        if (!done && 4'(k) <= p) begin
          ok = (FIELD_TEXT[k-1] == b);
          for (int j = 0; j < FIELD_LEN - 2; j++) begin
            idx = 5'({1'b0, p}) - 5'(k) + 5'd1 + 5'(j);
            if (j + 1 < k && idx < 5'(FIELD_LEN) && FIELD_TEXT[j] != FIELD_TEXT[idx[3:0]])
              ok = 1'b0;
          end
          if (ok) begin
            np   = 4'(k);
            done = 1'b1;
          end
        end
      end
    end
    return np;
  endfunction

endpackage

`default_nettype wire

[src/mubs_cell.sv]
// ----------------------------------------------------------------------------
// mubs_cell
// One delimiter position: holds its byte and whether the stream tail
// matches the delimiter up to and including this position.
// ----------------------------------------------------------------------------
`default_nettype none

module mubs_cell (
  input  wire logic       clk,
  input  wire logic       clear,
  input  wire logic       wr,
  input  wire logic [7:0] wr_byte,
  input  wire logic       step,
  input  wire logic       active,
  input  wire logic [7:0] data,
  input  wire logic       prev_match,
  output logic            match,
  output logic            match_next
);

  logic [7:0] store;

  assign match_next = active & prev_match & (data == store);

  always_ff @(posedge clk) begin
    if (wr) begin
      store <= wr_byte;
    end
    if (clear) begin
      match <= 1'b0;
    end else if (step && active) begin
      match <= match_next;
    end
  end

endmodule

`default_nettype wire

[src/multipart_upload_boundary_scanner.sv]
// One byte per cycle is taken while in_stall is low. The delimiter compare
// is a row of cells, one per delimiter position, the active ones updated in
// the cycle a payload byte arrives; a result passes from the byte that
// completes it through a snapshot stage and a length stage that locates any
// trailing partial delimiter into the output register. out_stall holds the
// result and pushes back on in_stall only when both result stages are full.
// ----------------------------------------------------------------------------
// multipart_upload_boundary_scanner
// Locates the uploaded file in a multipart body and reports offset, length
// and status once per stream.
// ----------------------------------------------------------------------------
`default_nettype none

module multipart_upload_boundary_scanner #(
  parameter int MAX_DELIMITER = mubs_pkg::MAX_DELIMITER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic             boundary_found,
  output logic [31:0]      file_offset,
  output logic [31:0]      payload_length
);
  import mubs_pkg::*;

  localparam int LW = $clog2(MAX_DELIMITER + 1);
  localparam int G  = (MAX_DELIMITER + 7) / 8;

  typedef enum logic [2:0] {
    PH_BOUNDARY, PH_FIELD, PH_HEADER, PH_PAYLOAD, PH_DRAIN
  } phase_t;

  phase_t      phase, phase_next;
  logic [LW-1:0] dlen, dlen_next, trim_len, trim_len_next;
  logic [3:0]  fprog, fprog_next;
  logic        lhf, lhf_next;
  logic [7:0]  prev_byte;
  logic [2:0]  crlf, crlf_next;
  logic [31:0] byte_pos, byte_pos_next, pay_start, pay_start_next;
  logic [32:0] count, count_next;
  logic        sent, sent_next;

  logic        acc, clear, step, bwr, found, produce, end_pay;
  logic [2:0]  prod_status;
  logic [2:0]  crlf_tmp;

  logic [MAX_DELIMITER-1:0] m_cur, m_next;
  logic [G*8-1:0]           nv;
  logic [G-1:0]             g_any;
  logic [2:0]               g_hi [G];

  // result snapshot
  logic          r1_valid, r1_pay, r1_bf;
  logic [2:0]    r1_status;
  logic [31:0]   r1_start;
  logic [32:0]   r1_count;
  logic [LW-1:0] r1_pend_dl;
  logic          r1_use_dl;
  logic [G-1:0]  r1_gany;
  logic [2:0]    r1_ghi [G];
  logic          out_take, r1_move;

  assign out_take = !out_valid || !out_stall;
  assign r1_move  = r1_valid && out_take;
  assign in_stall = r1_valid && !out_take;
  assign acc      = in_valid && !in_stall;
  assign clear    = rst || (acc && last_byte);
  assign step     = acc && (phase == PH_PAYLOAD);
  assign bwr      = acc && (phase == PH_BOUNDARY) && (data_byte != CH_LF)
                    && (dlen < LW'(MAX_DELIMITER));

  // delimiter cells
  for (genvar i = 0; i < MAX_DELIMITER; i++) begin : g_cell
    logic       c_wr;
    logic [7:0] c_wb;
    logic       c_prev;
    if (i == 0) begin : g_first
      assign c_wr   = clear;
      assign c_wb   = CH_CR;
      assign c_prev = 1'b1;
    end else if (i == 1) begin : g_second
      assign c_wr   = clear;
      assign c_wb   = CH_LF;
      assign c_prev = m_cur[i-1];
    end else begin : g_rest
      assign c_wr   = bwr && (dlen == LW'(i));
      assign c_wb   = data_byte;
      assign c_prev = m_cur[i-1];
    end
    mubs_cell u_cell (
      .clk        (clk),
      .clear      (clear),
      .wr         (c_wr),
      .wr_byte    (c_wb),
      .step       (step),
      .active     (LW'(i) < dlen),
      .data       (data_byte),
      .prev_match (c_prev),
      .match      (m_cur[i]),
      .match_next (m_next[i])
    );
  end

  always_comb begin
    nv = '0;
    nv[MAX_DELIMITER-1:0] = m_next;
    found = 1'b0;
    for (int i = 0; i < MAX_DELIMITER; i++) begin
      if (LW'(i + 1) == dlen && m_next[i]) found = step;
    end
    for (int g = 0; g < G; g++) begin
      g_any[g] = |nv[g*8 +: 8];
      g_hi[g]  = 3'd0;
      for (int j = 0; j < 8; j++) begin
        if (nv[g*8 + j]) g_hi[g] = 3'(j);
      end
    end
  end

  always_comb begin
    phase_next     = phase;
    dlen_next      = dlen;
    trim_len_next  = trim_len;
    fprog_next     = fprog;
    lhf_next       = lhf;
    crlf_next      = crlf;
    pay_start_next = pay_start;
    count_next     = count;
    sent_next      = sent;
    crlf_tmp       = crlf;
    byte_pos_next  = (byte_pos == 32'hFFFF_FFFF) ? byte_pos : byte_pos + 32'd1;
    unique case (phase)
      PH_BOUNDARY: begin
        if (data_byte == CH_LF) begin
          dlen_next  = trim_len;
          phase_next = lhf ? PH_HEADER : PH_FIELD;
          crlf_next  = 3'd0;
          fprog_next = 4'd0;
          lhf_next   = 1'b0;
        end else begin
          if (dlen < LW'(MAX_DELIMITER)) begin
            dlen_next = dlen + LW'(1);
            if (data_byte != CH_CR) trim_len_next = dlen + LW'(1);
          end
          if (!lhf) begin
            fprog_next = field_next(fprog, data_byte);
            lhf_next   = (fprog_next == 4'(FIELD_LEN));
          end
        end
      end
      PH_FIELD: begin
        if (data_byte == CH_LF) begin
          if (lhf) begin
            phase_next = PH_HEADER;
            crlf_next  = (prev_byte == CH_CR) ? 3'd2 : 3'd0;
          end
          fprog_next = 4'd0;
          lhf_next   = 1'b0;
        end else if (!lhf) begin
          fprog_next = field_next(fprog, data_byte);
          lhf_next   = (fprog_next == 4'(FIELD_LEN));
        end
      end
      PH_HEADER: begin
        if (data_byte == CH_CR) begin
          if (crlf == 3'd0 || crlf == 3'd2) crlf_tmp = crlf + 3'd1;
          else if (crlf == 3'd3) crlf_tmp = 3'd1;
        end else if (data_byte == CH_LF) begin
          crlf_tmp = (crlf == 3'd2) ? 3'd0 : crlf + 3'd1;
        end else begin
          crlf_tmp = 3'd0;
        end
        crlf_next = crlf_tmp;
        if (crlf_tmp >= 3'd4) begin
          pay_start_next = byte_pos_next;
          phase_next     = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        count_next = (&count) ? count : count + 33'd1;
        if (found) begin
          sent_next  = 1'b1;
          phase_next = PH_DRAIN;
        end
      end
      default: begin
      end
    endcase

    end_pay     = 1'b0;
    prod_status = ST_OK;
    produce     = acc && (found || (last_byte && !sent));
    if (!found) begin
      priority case (phase_next)
        PH_BOUNDARY: prod_status = ST_NO_BOUNDARY;
        PH_FIELD:    prod_status = ST_NO_FIELD;
        PH_HEADER:   prod_status = ST_NO_HDR_END;
        default:     end_pay     = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BOUNDARY;
      dlen      <= LW'(2);
      trim_len  <= LW'(2);
      fprog     <= 4'd0;
      lhf       <= 1'b0;
      prev_byte <= 8'd0;
      crlf      <= 3'd0;
      byte_pos  <= 32'd0;
      pay_start <= 32'd0;
      count     <= 33'd0;
      sent      <= 1'b0;
    end else if (acc) begin
      if (last_byte) begin
        phase     <= PH_BOUNDARY;
        dlen      <= LW'(2);
        trim_len  <= LW'(2);
        fprog     <= 4'd0;
        lhf       <= 1'b0;
        prev_byte <= 8'd0;
        crlf      <= 3'd0;
        byte_pos  <= 32'd0;
        pay_start <= 32'd0;
        count     <= 33'd0;
        sent      <= 1'b0;
      end else begin
        phase     <= phase_next;
        dlen      <= dlen_next;
        trim_len  <= trim_len_next;
        fprog     <= fprog_next;
        lhf       <= lhf_next;
        prev_byte <= data_byte;
        crlf      <= crlf_next;
        byte_pos  <= byte_pos_next;
        pay_start <= pay_start_next;
        count     <= count_next;
        sent      <= sent_next;
      end
    end
  end

  // snapshot stage
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (acc && produce) begin
      r1_valid <= 1'b1;
    end else if (r1_move) begin
      r1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && produce) begin
      r1_pay     <= found || end_pay;
      r1_bf      <= found;
      r1_status  <= prod_status;
      r1_start   <= pay_start_next;
      r1_count   <= count_next;
      r1_use_dl  <= found;
      r1_pend_dl <= dlen;
      r1_gany    <= g_any;
      r1_ghi     <= g_hi;
    end
  end

  // length stage: longest partial delimiter at the tail, or the whole delimiter once found
  logic [LW-1:0] pend;
  logic [32:0]   len33;
  logic [31:0]   len32;

  always_comb begin
    pend = '0;
    for (int g = 0; g < G; g++) begin
      if (r1_gany[g]) pend = LW'(g * 8) + LW'(r1_ghi[g]) + LW'(1);
    end
    if (r1_use_dl) pend = r1_pend_dl;
    len33 = r1_count - 33'(pend);
    len32 = len33[32] ? 32'hFFFF_FFFF : len33[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r1_move) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r1_move) begin
      boundary_found <= r1_bf;
      if (r1_pay) begin
        status         <= (len32 == 32'd0) ? ST_EMPTY : ST_OK;
        file_offset    <= r1_start;
        payload_length <= len32;
      end else begin
        status         <= r1_status;
        file_offset    <= 32'd0;
        payload_length <= 32'd0;
      end
    end
  end

endmodule

`default_nettype wire

[src/mubs_checker.sv]
// ----------------------------------------------------------------------------
// mubs_checker
// Port-level checks on the scanner's result requests.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multipart_upload_boundary_scanner_defines.svh"

module mubs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  status,
  input wire logic        boundary_found,
  input wire logic [31:0] file_offset,
  input wire logic [31:0] payload_length
);
  import mubs_pkg::*;

  `MUBS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid, "stalled request dropped")
  `MUBS_ASSERT_NOW(a_fail_zero, out_valid && status != ST_OK && status != ST_EMPTY, file_offset == 32'd0 && payload_length == 32'd0 && !boundary_found, "error request carries data")
  `MUBS_ASSERT_NOW(a_empty_len, out_valid && (status == ST_EMPTY || status == ST_OK), (status == ST_EMPTY) == (payload_length == 32'd0), "empty status disagrees with length")
  `MUBS_ASSERT_NOW(a_found_ok, out_valid && boundary_found, status == ST_OK || status == ST_EMPTY, "delimiter seen with error status")

endmodule

bind multipart_upload_boundary_scanner mubs_checker u_mubs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .boundary_found (boundary_found),
  .file_offset    (file_offset),
  .payload_length (payload_length)
);

`default_nettype wire

[tb/multipart_upload_boundary_scanner_tb.sv]
// ----------------------------------------------------------------------------
// multipart_upload_boundary_scanner_tb
// Feeds multipart bodies byte by byte, well-formed and broken, predicts the
// offset, length and status of each stream and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multipart_upload_boundary_scanner_tb;
  import mubs_pkg::*;

  localparam int DLIM_MAX = 80;
  localparam int RANDOM_BYTES = 1800;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [2:0] PH_BOUNDARY = 3'd0;
  localparam logic [2:0] PH_FIELD    = 3'd1;
  localparam logic [2:0] PH_HEADER   = 3'd2;
  localparam logic [2:0] PH_PAYLOAD  = 3'd3;
  localparam logic [2:0] PH_DRAIN    = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } upload_byte_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] offset;
    logic [31:0] length;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = 8'd0;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic boundary_found;
  logic [31:0] file_offset;
  logic [31:0] payload_length;

  multipart_upload_boundary_scanner DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .boundary_found(boundary_found),
    .file_offset(file_offset), .payload_length(payload_length)
  );

  upload_byte_t pending_bytes[$];
  logic [7:0] stream_buf[$];
  scan_result_t expected_results[$];
  int total_bytes = 0;
  int bytes_offered = 0;
  int failures = 0;
  int cycles = 0;
  int hold_off = 0;
  bit hold_done = 0;
  bit req_taken = 0;

  // scanner model state
  logic [2:0]  ph;
  logic [7:0]  dlim [DLIM_MAX];
  int          dlim_len;
  logic [DLIM_MAX-1:0] hits;
  logic [3:0]  fprog;
  logic        has_field;
  logic [7:0]  prev_b;
  int          crlf;
  logic [31:0] bpos;
  logic [31:0] pstart;
  logic [31:0] bcount;
  logic        sent;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] advance_field(logic [3:0] p, logic [7:0] b);
    logic [7:0] seen [16];
    bit ok;
    for (int i = 0; i < 16; i++) seen[i] = (i < p) ? FIELD_TEXT[i] : 8'd0;
    seen[p] = b;
    for (int k = p + 1; k >= 1; k--) begin
      ok = 1;
      for (int j = 0; j < k; j++)
        if (FIELD_TEXT[j] != seen[p + 1 - k + j]) ok = 0;
      if (ok) return 4'(k);
    end
    return 4'd0;
  endfunction

  task automatic rearm_scanner();
    ph = PH_BOUNDARY;
    for (int i = 0; i < DLIM_MAX; i++) dlim[i] = 8'd0;
    dlim[0] = CH_CR;
    dlim[1] = CH_LF;
    dlim_len = 2;
    hits = '0;
    fprog = 0;
    has_field = 0;
    prev_b = 0;
    crlf = 0;
    bpos = 0;
    pstart = 0;
    bcount = 0;
    sent = 0;
  endtask

  task automatic feed_field(logic [7:0] b);
    if (!has_field) begin
      fprog = advance_field(fprog, b);
      if (fprog >= 4'(FIELD_LEN)) has_field = 1;
    end
  endtask

  function automatic int partial_len();
    for (int i = dlim_len; i > 0; i--)
      if (hits[i-1]) return i;
    return 0;
  endfunction

  task automatic add_body(int n);
    if (bcount > 32'hFFFF_FFFF - 32'(n)) bcount = 32'hFFFF_FFFF;
    else bcount = bcount + 32'(n);
  endtask

  task automatic push_result(logic [2:0] st, logic f, logic [31:0] o, logic [31:0] l);
    scan_result_t r;
    r.status = st;
    r.found = f;
    r.offset = o;
    r.length = l;
    expected_results.push_back(r);
  endtask

  task automatic scan_byte(logic [7:0] b, logic last);
    int oldp;
    logic prv;
    if (bpos != 32'hFFFF_FFFF) bpos++;
    case (ph)
      PH_BOUNDARY: begin
        if (b == CH_LF) begin
          while (dlim_len > 2 && dlim[dlim_len-1] == CH_CR) dlim_len--;
          ph = has_field ? PH_HEADER : PH_FIELD;
          crlf = 0;
          fprog = 0;
          has_field = 0;
        end else begin
          if (dlim_len < DLIM_MAX) begin
            dlim[dlim_len] = b;
            dlim_len++;
          end
          feed_field(b);
        end
      end
      PH_FIELD: begin
        if (b == CH_LF) begin
          if (has_field) begin
            ph = PH_HEADER;
            crlf = (prev_b == CH_CR) ? 2 : 0;
          end
          fprog = 0;
          has_field = 0;
        end else begin
          feed_field(b);
        end
      end
      PH_HEADER: begin
        if (b == CH_CR) begin
          if (crlf == 0 || crlf == 2) crlf++;
          else if (crlf == 3) crlf = 1;
        end else if (b == CH_LF) begin
          // a lone LF still moves the header-end search on, unless crlf is 2
          if (crlf == 2) crlf = 0;
          else crlf++;
        end else begin
          crlf = 0;
        end
        if (crlf >= 4) begin
          pstart = bpos;
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        oldp = partial_len();
        for (int i = dlim_len - 1; i >= 0; i--) begin
          prv = (i == 0) ? 1'b1 : hits[i-1];
          hits[i] = prv && (b == dlim[i]);
        end
        if (hits[dlim_len-1]) begin
          add_body(oldp + 1 - dlim_len);
          push_result(bcount == 0 ? ST_EMPTY : ST_OK, 1'b1, pstart, bcount);
          sent = 1;
          ph = PH_DRAIN;
        end else begin
          add_body(oldp + 1 - partial_len());
        end
      end
      default: ;
    endcase
    prev_b = b;
    if (last) begin
      if (!sent) begin
        if (ph == PH_BOUNDARY) push_result(ST_NO_BOUNDARY, 1'b0, 0, 0);
        else if (ph == PH_FIELD) push_result(ST_NO_FIELD, 1'b0, 0, 0);
        else if (ph == PH_HEADER) push_result(ST_NO_HDR_END, 1'b0, 0, 0);
        else push_result(bcount == 0 ? ST_EMPTY : ST_OK, 1'b0, pstart, bcount);
      end
      rearm_scanner();
    end
  endtask

  // ---------------- stream building ----------------
  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) stream_buf.push_back(s[i]);
  endtask

  task automatic put_crlf();
    stream_buf.push_back(CH_CR);
    stream_buf.push_back(CH_LF);
  endtask

  function automatic logic [7:0] plain_char();
    return 8'($urandom_range(33, 126));
  endfunction

  task automatic put_random(int n);
    for (int i = 0; i < n; i++) stream_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic close_stream();
    upload_byte_t u;
    foreach (stream_buf[i]) begin
      u.data = stream_buf[i];
      u.last = (i == stream_buf.size() - 1);
      pending_bytes.push_back(u);
    end
    total_bytes += stream_buf.size();
    stream_buf.delete();
  endtask

  // boundary, a few header lines, the filename line, header end, payload
  task automatic build_upload(bit truncate);
    logic [7:0] bnd[$];
    int cut;
    bnd.push_back("-");
    bnd.push_back("-");
    repeat ($urandom_range(1, 8)) bnd.push_back(plain_char());
    foreach (bnd[i]) stream_buf.push_back(bnd[i]);
    if ($urandom_range(0, 3) == 0) stream_buf.push_back(CH_CR);
    put_crlf();
    repeat ($urandom_range(0, 2)) begin
      put_text("X-h: ");
      repeat ($urandom_range(0, 4)) stream_buf.push_back(plain_char());
      put_crlf();
    end
    put_text("Content-Disposition: form-data; ");
    if ($urandom_range(0, 4) == 0) put_text("name=\"name=\"filename\"");
    else put_text("name=\"filename\"");
    if ($urandom_range(0, 2) == 0) stream_buf.push_back(CH_LF);
    else put_crlf();
    if ($urandom_range(0, 1)) begin
      put_text("Type: x");
      put_crlf();
    end
    case ($urandom_range(0, 2))
      0: put_crlf();
      1: stream_buf.push_back(CH_LF);
      default: begin
        stream_buf.push_back(CH_CR);
        put_crlf();
      end
    endcase
    repeat ($urandom_range(0, 3)) begin
      put_random($urandom_range(0, 12));
      // CRLF and a prefix of the boundary, up to all of it, inside the payload
      if ($urandom_range(0, 1)) begin
        put_crlf();
        for (int i = 0; i < $urandom_range(0, bnd.size()); i++)
          stream_buf.push_back(bnd[i]);
      end
    end
    if (!truncate) begin
      put_crlf();
      foreach (bnd[i]) stream_buf.push_back(bnd[i]);
      put_text("--");
      if ($urandom_range(0, 1)) put_random($urandom_range(1, 6));
    end else if (stream_buf.size() > 1) begin
      cut = $urandom_range(1, stream_buf.size());
      while (stream_buf.size() > cut) void'(stream_buf.pop_back());
    end
    close_stream();
  endtask

  task automatic build_random_stream();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 65) build_upload(1'b0);
    else if (kind < 85) build_upload(1'b1);
    else if (kind < 95) begin
      put_random($urandom_range(1, 20));
      close_stream();
    end else begin
      repeat ($urandom_range(70, 110)) stream_buf.push_back(plain_char());
      if ($urandom_range(0, 1)) put_crlf();
      put_random($urandom_range(0, 8));
      close_stream();
    end
  endtask

  task automatic build_directed();
    // plain upload
    put_text("--ab"); put_crlf();
    put_text("name=\"filename\""); put_crlf(); put_crlf();
    put_text("XYZ"); put_crlf(); put_text("--ab--");
    close_stream();
    // empty payload
    put_text("--q"); put_crlf();
    put_text("name=\"filename\""); put_crlf(); put_crlf(); put_crlf(); put_text("--q");
    close_stream();
    // no boundary line end, single extreme bytes
    put_text("abc"); close_stream();
    stream_buf.push_back(8'hFF); close_stream();
    stream_buf.push_back(8'h00); close_stream();
    // no filename field
    put_text("--b"); put_crlf(); put_text("name=x"); put_crlf(); close_stream();
    // field but header end missing
    put_text("--b"); put_crlf(); put_text("name=\"filename\""); put_crlf(); put_text("z");
    close_stream();
    // field on the boundary line, lone LFs that do not end the header
    put_text("--x name=\"filename\""); stream_buf.push_back(CH_LF);
    stream_buf.push_back(CH_LF); stream_buf.push_back(CH_LF);
    put_text("pp"); put_crlf(); put_text("--x name");
    close_stream();
    // stream ends on a partial delimiter
    put_text("--cd"); put_crlf(); put_text("name=\"filename\""); put_crlf(); put_crlf();
    put_text("AB"); put_crlf(); put_text("--c");
    close_stream();
    // overlong boundary line with trailing CRs
    repeat (90) stream_buf.push_back("k");
    stream_buf.push_back(CH_CR); put_crlf();
    put_text("name=\"filename\""); put_crlf(); put_crlf(); put_text("data");
    close_stream();
  endtask

  // ---------------- driver ----------------
  always @(negedge clk) begin
    upload_byte_t u;
    int sidle;
    if (!rst && !(in_valid && !req_taken)) begin
      sidle = (bytes_offered * 3 < total_bytes) ? 30 :
              (bytes_offered * 3 < total_bytes * 2) ? 66 : 0;
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sidle) begin
        u = pending_bytes.pop_front();
        in_valid <= 1'b1;
        data_byte <= u.data;
        last_byte <= u.last;
        bytes_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off so the result stages back up
  always @(negedge clk) begin
    int ridle;
    if (!rst) begin
      ridle = (bytes_offered * 3 < total_bytes) ? 66 :
              (bytes_offered * 3 < total_bytes * 2) ? 30 : 0;
      if (!hold_done && bytes_offered * 3 >= total_bytes) begin
        hold_done = 1;
        hold_off = 300;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < ridle);
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    scan_result_t e;
    req_taken = 0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        req_taken = 1;
        scan_byte(data_byte, last_byte);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          failures++;
          $display("%0t: unexpected result status %0d length %0d", $time, status,
                   payload_length);
        end else begin
          e = expected_results.pop_front();
          if (status !== e.status) begin
            failures++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          end
          if (boundary_found !== e.found) begin
            failures++;
            $display("%0t: boundary_found expected %0d actual %0d", $time, e.found,
                     boundary_found);
          end
          if (file_offset !== e.offset) begin
            failures++;
            $display("%0t: file_offset expected %0d actual %0d", $time, e.offset,
                     file_offset);
          end
          if (payload_length !== e.length) begin
            failures++;
            $display("%0t: payload_length expected %0d actual %0d", $time, e.length,
                     payload_length);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rearm_scanner();
    build_directed();
    while (total_bytes < RANDOM_BYTES) build_random_stream();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (pending_bytes.size() != 0 || (in_valid && !req_taken)) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
